// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property held at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: hw/rtl/elx_pkg.sv
package elx_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } elx_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] result_kind;
    } elx_out_t;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_DASH      = 8'h2d;
    localparam logic [7:0] CH_EQUAL     = 8'h3d;
    localparam logic [7:0] CH_COLON     = 8'h3a;
    localparam logic [7:0] CH_COMMA     = 8'h2c;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;

    typedef enum logic [10:0] {
        ST_INIT    = 11'b000_0000_0001,
        ST_BSI     = 11'b000_0000_0010,
        ST_COMMENT = 11'b000_0000_0100,
        ST_DIR     = 11'b000_0000_1000,
        ST_BS1     = 11'b000_0001_0000,
        ST_WS1     = 11'b000_0010_0000,
        ST_OPT     = 11'b000_0100_0000,
        ST_BS2     = 11'b000_1000_0000,
        ST_WS2     = 11'b001_0000_0000,
        ST_GRP     = 11'b010_0000_0000,
        ST_BS3     = 11'b100_0000_0000
    } elx_state_t;

endpackage

// File: hw/rtl/elx_in_reg.sv
module elx_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  elx_pkg::elx_in_t s_data,
    input  logic            advance,
    output logic            item_valid,
    output elx_pkg::elx_in_t item
);
    import elx_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    elx_in_t data_reg;
    logic    load;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;
endmodule

// File: hw/rtl/elx_lexer.sv
module elx_lexer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  elx_pkg::elx_in_t item,
    output logic             emit,
    output elx_pkg::elx_out_t res
);
    import elx_pkg::*;

    elx_state_t state_reg;
    elx_state_t state_next;
    logic       crd_reg;
    logic       crd_next;
    logic       lhd_reg;
    logic       lhd_next;
    logic [7:0] last_reg;
    logic [7:0] last_next;

    logic [7:0] c;
    logic       is_sep;
    logic       do_keep;
    logic [7:0] keep_c;
    logic       do_fin;
    logic [1:0] fin_kind;
    logic       do_cmt;
    logic       cmt_done;
    elx_state_t go_st;

    assign c      = (item.char_in == CH_TAB) ? CH_SPACE : item.char_in;
    assign is_sep = (last_reg == CH_DASH) || (last_reg == CH_EQUAL) ||
                    (last_reg == CH_COLON) || (last_reg == CH_COMMA);

    // decode one character
    always_comb begin
        do_keep  = 1'b0;
        keep_c   = c;
        do_fin   = 1'b0;
        fin_kind = KIND_LINE;
        do_cmt   = 1'b0;
        cmt_done = 1'b1;
        go_st    = state_reg;
        if (item.end_of_input) begin
            do_fin   = 1'b1;
            fin_kind = lhd_reg ? KIND_LINE : KIND_NONE;
        end else begin
            unique case (state_reg)
                ST_BSI: begin
                    if (c == CH_SPACE || c == CH_NEWLINE) begin
                        go_st = ST_INIT;
                    end else begin
                        do_keep = 1'b1;
                        go_st   = ST_DIR;
                    end
                end
                ST_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        if (crd_reg) begin
                            do_fin = 1'b1;
                        end else begin
                            go_st = ST_INIT;
                        end
                    end
                end
                ST_DIR: begin
                    priority if (c == CH_SPACE) begin
                        do_keep = 1'b1;
                        go_st   = ST_WS1;
                    end else if (c == CH_BACKSLASH) begin
                        go_st = ST_BS1;
                    end else if (c == CH_HASH) begin
                        do_cmt = 1'b1;
                    end else if (c == CH_NEWLINE) begin
                        do_fin = 1'b1;
                    end else begin
                        do_keep = 1'b1;
                        go_st   = ST_DIR;
                    end
                end
                ST_BS1: begin
                    do_keep = 1'b1;
                    if (c == CH_SPACE || c == CH_NEWLINE) begin
                        keep_c = CH_SPACE;
                        go_st  = ST_WS1;
                    end else begin
                        go_st = ST_DIR;
                    end
                end
                ST_WS1: begin
                    priority if (c == CH_SPACE) begin
                        go_st = ST_WS1;
                    end else if (c == CH_BACKSLASH) begin
                        go_st = ST_BS2;
                    end else if (c == CH_HASH) begin
                        do_cmt = 1'b1;
                    end else if (c == CH_NEWLINE) begin
                        do_fin = 1'b1;
                    end else if (c == CH_DASH) begin
                        do_keep = 1'b1;
                        go_st   = ST_OPT;
                    end else begin
                        do_keep = 1'b1;
                        go_st   = ST_GRP;
                    end
                end
                ST_OPT: begin
                    priority if (c == CH_SPACE) begin
                        do_keep = 1'b1;
                        go_st   = ST_WS2;
                    end else if (c == CH_BACKSLASH) begin
                        go_st = ST_BS2;
                    end else if (c == CH_HASH) begin
                        do_cmt = 1'b1;
                    end else if (c == CH_NEWLINE) begin
                        do_fin = 1'b1;
                    end else begin
                        do_keep = 1'b1;
                        go_st   = ST_OPT;
                    end
                end
                ST_BS2: begin
                    priority if (c == CH_SPACE) begin
                        do_keep = 1'b1;
                        go_st   = ST_WS2;
                    end else if (c == CH_NEWLINE) begin
                        // continuation after a separator is dropped
                        priority if (is_sep) begin
                            go_st = ST_OPT;
                        end else if (last_reg == CH_SPACE) begin
                            go_st = ST_WS2;
                        end else begin
                            do_keep = 1'b1;
                            keep_c  = CH_SPACE;
                            go_st   = ST_WS2;
                        end
                    end else begin
                        do_keep = 1'b1;
                        go_st   = ST_OPT;
                    end
                end
                ST_WS2: begin
                    priority if (c == CH_SPACE) begin
                        go_st = ST_WS2;
                    end else if (c == CH_BACKSLASH) begin
                        go_st = ST_BS3;
                    end else if (c == CH_HASH) begin
                        do_cmt = 1'b1;
                    end else if (c == CH_NEWLINE) begin
                        do_fin = 1'b1;
                    end else begin
                        do_keep = 1'b1;
                        go_st   = ST_GRP;
                    end
                end
                ST_GRP: begin
                    priority if (c == CH_SPACE) begin
                        do_keep = 1'b1;
                        go_st   = ST_WS2;
                    end else if (c == CH_BACKSLASH) begin
                        go_st = ST_BS3;
                    end else if (c == CH_HASH) begin
                        do_cmt = 1'b1;
                    end else if (c == CH_NEWLINE) begin
                        do_fin = 1'b1;
                    end else begin
                        do_keep = 1'b1;
                        go_st   = ST_GRP;
                    end
                end
                ST_BS3: begin
                    do_keep = 1'b1;
                    if (c == CH_SPACE || c == CH_NEWLINE) begin
                        keep_c = CH_SPACE;
                        go_st  = ST_WS2;
                    end else begin
                        go_st = ST_GRP;
                    end
                end
                default: begin
                    // start of line
                    priority if (c == CH_SPACE || c == CH_NEWLINE) begin
                        go_st = ST_INIT;
                    end else if (c == CH_BACKSLASH) begin
                        go_st = ST_BSI;
                    end else if (c == CH_HASH) begin
                        do_cmt   = 1'b1;
                        cmt_done = 1'b0;
                    end else begin
                        do_keep = 1'b1;
                        go_st   = ST_DIR;
                    end
                end
            endcase
        end
    end

    // apply the decoded action
    always_comb begin
        state_next = state_reg;
        crd_next   = crd_reg;
        lhd_next   = lhd_reg;
        last_next  = last_reg;
        emit       = 1'b0;
        res        = '0;
        if (step) begin
            priority if (do_fin) begin
                emit            = 1'b1;
                res.result_kind = fin_kind;
                state_next      = ST_INIT;
                crd_next        = 1'b0;
                lhd_next        = 1'b0;
            end else if (do_keep) begin
                emit            = 1'b1;
                res.out_char    = keep_c;
                res.result_kind = KIND_CHAR;
                lhd_next        = 1'b1;
                last_next       = keep_c;
                state_next      = go_st;
            end else if (do_cmt) begin
                crd_next   = cmt_done;
                state_next = ST_COMMENT;
            end else begin
                state_next = go_st;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            crd_reg   <= 1'b0;
            lhd_reg   <= 1'b0;
            last_reg  <= '0;
        end else begin
            state_reg <= state_next;
            crd_reg   <= crd_next;
            lhd_reg   <= lhd_next;
            last_reg  <= last_next;
        end
    end
endmodule

// File: hw/rtl/elx_out_reg.sv
module elx_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              emit,
    input  elx_pkg::elx_out_t res,
    output logic              m_valid,
    input  logic              m_ready,
    output elx_pkg::elx_out_t m_data
);
    import elx_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    elx_out_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = emit;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;
endmodule

// File: hw/rtl/export_line_lexer.sv
// Line lexer for exports-style text: one byte or end-of-input marker per request, at
// most one result per request (a kept character, a line-complete marker, or an
// input-ended-with-no-line marker). A request is taken every cycle while results
// drain; a byte passes through the input register and then the result register,
// with the lexer state updated in a single pass between them.
// s_ready follows m_ready combinationally when input and result registers are full.
module export_line_lexer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  elx_pkg::elx_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output elx_pkg::elx_out_t m_data
);
    import elx_pkg::*;

    logic     item_valid;
    elx_in_t  item;
    logic     advance;
    logic     emit;
    elx_out_t res;

    assign advance = item_valid && (!m_valid || m_ready);

    elx_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    elx_lexer u_lex (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item),
        .emit    (emit),
        .res     (res)
    );

    elx_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .emit    (emit),
        .res     (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

// File: hw/rtl/elx_checker.sv
`include "assert_macros.svh"

module elx_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input elx_pkg::elx_out_t m_data
);
    import elx_pkg::*;

    // stalled result holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // no undefined result kind
    `ASSERT_IMPLY(a_kind, aclk, aresetn, m_valid, m_data.result_kind <= KIND_NONE)
    // markers carry no character
    `ASSERT_IMPLY(a_marker, aclk, aresetn, m_valid && m_data.result_kind != KIND_CHAR,
                  m_data.out_char == 8'd0)
    // handshake outputs are always defined
    `ASSERT_ALWAYS(a_known, aclk, aresetn, !$isunknown({s_ready, m_valid}))
    // a draining consumer never stalls the source
    `ASSERT_IMPLY(a_ready, aclk, aresetn, m_ready, s_ready)
endmodule

bind export_line_lexer elx_checker u_elx_checker (.*);
